FILE: design/xcbc_pkg.sv
// Shared types, constants and helper functions for the XTEA CBC block with encrypted IV.
// This file has no dependencies. The controller, the datapath and the top level all use it.
package xcbc_pkg;

  // These are cipher constants.
  localparam int unsigned ROUNDS = 32;
  localparam logic [31:0] DELTA = 32'h9E37_79B9;
  localparam logic [63:0] SUM_DEC_WIDE = 64'(DELTA) * 64'(ROUNDS);
  localparam logic [31:0] SUM_DEC = SUM_DEC_WIDE[31:0];

  // The round counter counts from 0 up to ROUNDS-1.
  localparam int unsigned CNT_W = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
  localparam logic [CNT_W-1:0] LAST_RND = CNT_W'(ROUNDS - 1);

  // These are the block modes carried in the input beat.
  localparam logic MODE_ENCRYPT = 1'b0;
  localparam logic MODE_DECRYPT = 1'b1;

  // These are the indexes of the configuration registers.
  localparam int unsigned CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DATA_KEY0 = 3'd0,
    REG_DATA_KEY1 = 3'd1,
    REG_DATA_KEY2 = 3'd2,
    REG_DATA_KEY3 = 3'd3,
    REG_IV_KEY0   = 3'd4,
    REG_IV_KEY1   = 3'd5,
    REG_IV_KEY2   = 3'd6,
    REG_IV_KEY3   = 3'd7
  } cfg_reg_t;

  // These are the channel payloads.
  typedef struct packed {
    logic        mode;
    logic        start_message;
    logic [31:0] iv_first_word;
    logic [31:0] iv_second_word;
    logic [31:0] block_first_word;
    logic [31:0] block_second_word;
  } src_beat_t;

  typedef struct packed {
    logic [31:0] result_first_word;
    logic [31:0] result_second_word;
  } dst_beat_t;

  // These are the controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_IV_RUN,
    ST_DATA_RUN
  } state_t;

  // These are the commands from the controller to the datapath.
  typedef struct packed {
    logic capture;       // latch the input beat
    logic start_iv;      // load the IV into the round registers under the IV key
    logic start_data_in; // load the input block, chained with the stored chain value when encrypting
    logic start_data_iv; // the IV is done, so seed the chain and load the latched block
    logic step;          // apply one full round
    logic finish;        // write the result and update the chain
  } ctrl_cmd_t;

  // This is the status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
  } ctrl_sts_t;

  // This is the XTEA word mix.
  function automatic logic [31:0] mix_word(input logic [31:0] x);
    return ((x << 4) ^ (x >> 5)) + x;
  endfunction

endpackage

FILE: design/xcbc_ctrl.sv
// Sequencer for the XTEA CBC block: the IV pass, the data pass and the round counter.
// It depends on xcbc_pkg and drives the xcbc_dp datapath through command and status structs.
module xcbc_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  src_valid,
  output logic                  src_ready,
  input  logic                  start_message,
  output xcbc_pkg::ctrl_cmd_t   cmd,
  input  xcbc_pkg::ctrl_sts_t   sts
);

  xcbc_pkg::state_t             state;
  xcbc_pkg::state_t             state_next;
  logic [xcbc_pkg::CNT_W-1:0]   cnt;
  logic [xcbc_pkg::CNT_W-1:0]   cnt_next;
  logic                         last;

  assign last = (cnt == xcbc_pkg::LAST_RND);

  // The state and the round counter are registered here.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= xcbc_pkg::ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // This block computes the next state and the next counter value.
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    case (state)
      xcbc_pkg::ST_IDLE: begin
        cnt_next = '0;
        if (src_valid) begin
          state_next = start_message ? xcbc_pkg::ST_IV_RUN : xcbc_pkg::ST_DATA_RUN;
        end
      end
      xcbc_pkg::ST_IV_RUN: begin
        if (last) begin
          cnt_next   = '0;
          state_next = xcbc_pkg::ST_DATA_RUN;
        end else begin
          cnt_next = cnt + xcbc_pkg::CNT_W'(1);
        end
      end
      xcbc_pkg::ST_DATA_RUN: begin
        if (!last) begin
          cnt_next = cnt + xcbc_pkg::CNT_W'(1);
        end else if (sts.out_free) begin
          cnt_next   = '0;
          state_next = xcbc_pkg::ST_IDLE;
        end
      end
      default: begin
        cnt_next   = '0;
        state_next = xcbc_pkg::ST_IDLE;
      end
    endcase
  end

  // This block drives the commands to the datapath.
  always_comb begin
    cmd       = '0;
    src_ready = 1'b0;
    case (state)
      xcbc_pkg::ST_IDLE: begin
        src_ready = 1'b1;
        if (src_valid) begin
          cmd.capture       = 1'b1;
          cmd.start_iv      = start_message;
          cmd.start_data_in = !start_message;
        end
      end
      xcbc_pkg::ST_IV_RUN: begin
        cmd.step          = 1'b1;
        cmd.start_data_iv = last;
      end
      xcbc_pkg::ST_DATA_RUN: begin
        // The last round waits until the output register can take the result.
        cmd.step   = !last || sts.out_free;
        cmd.finish = last && sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  // A finished block always returns the sequencer to idle.
  a_finish_to_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> state == xcbc_pkg::ST_IDLE)
    else $error("finish did not return to idle");

  // The data pass always starts from round zero after the IV pass.
  a_iv_to_data: assert property (@(posedge clk) disable iff (rst)
    cmd.start_data_iv |=> (state == xcbc_pkg::ST_DATA_RUN) && (cnt == '0))
    else $error("data pass did not start at round zero");

  // The round counter never runs past the last round.
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= xcbc_pkg::LAST_RND)
    else $error("round counter out of range");

  // The last data round is applied only together with the result write.
  a_last_step: assert property (@(posedge clk) disable iff (rst)
    (state == xcbc_pkg::ST_DATA_RUN) && last && cmd.step |-> cmd.finish)
    else $error("last round applied without writing the result");

endmodule

FILE: design/xcbc_dp.sv
// Datapath for the XTEA CBC block: key registers, chain value, round unit and output register.
// It depends on xcbc_pkg and is driven by the xcbc_ctrl sequencer.
module xcbc_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  xcbc_pkg::src_beat_t             src_beat,
  output xcbc_pkg::dst_beat_t             dst_beat,
  output logic                            dst_valid,
  input  logic                            dst_ready,
  input  logic                            cfg_we,
  input  logic [xcbc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                     cfg_data,
  input  xcbc_pkg::ctrl_cmd_t             cmd,
  output xcbc_pkg::ctrl_sts_t             sts
);

  logic [3:0][31:0] data_key;
  logic [3:0][31:0] iv_key;
  logic [63:0]      chain;
  logic [63:0]      blk;
  logic             decrypt;
  logic             use_iv_key;
  logic [31:0]      wa;
  logic [31:0]      wb;
  logic [31:0]      sum;

  logic [3:0][31:0] key_sel;
  logic             enc_dir;
  logic [31:0]      e_a, e_s, e_b;
  logic [31:0]      d_a, d_s, d_b;
  logic [63:0]      round_out;
  logic [63:0]      src_blk;

  assign sts.out_free = !dst_valid || dst_ready;
  assign src_blk      = {src_beat.block_first_word, src_beat.block_second_word};

  // The configuration registers are written here.
  always_ff @(posedge clk) begin
    if (rst) begin
      data_key <= '0;
      iv_key   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        xcbc_pkg::REG_DATA_KEY0: data_key[0] <= cfg_data;
        xcbc_pkg::REG_DATA_KEY1: data_key[1] <= cfg_data;
        xcbc_pkg::REG_DATA_KEY2: data_key[2] <= cfg_data;
        xcbc_pkg::REG_DATA_KEY3: data_key[3] <= cfg_data;
        xcbc_pkg::REG_IV_KEY0:   iv_key[0]   <= cfg_data;
        xcbc_pkg::REG_IV_KEY1:   iv_key[1]   <= cfg_data;
        xcbc_pkg::REG_IV_KEY2:   iv_key[2]   <= cfg_data;
        xcbc_pkg::REG_IV_KEY3:   iv_key[3]   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // One full XTEA round runs in each direction, and the direction is then selected.
  // The IV is always enciphered.
  always_comb begin
    key_sel = use_iv_key ? iv_key : data_key;
    enc_dir = use_iv_key || !decrypt;

    e_a = wa + (xcbc_pkg::mix_word(wb) ^ (sum + key_sel[sum[1:0]]));
    e_s = sum + xcbc_pkg::DELTA;
    e_b = wb + (xcbc_pkg::mix_word(e_a) ^ (e_s + key_sel[e_s[12:11]]));

    d_b = wb - (xcbc_pkg::mix_word(wa) ^ (sum + key_sel[sum[12:11]]));
    d_s = sum - xcbc_pkg::DELTA;
    d_a = wa - (xcbc_pkg::mix_word(d_b) ^ (d_s + key_sel[d_s[1:0]]));

    round_out = enc_dir ? {e_a, e_b} : {d_a, d_b};
  end

  // These are the latched block and its mode.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      blk     <= src_blk;
      decrypt <= src_beat.mode;
    end
  end

  // These are the round registers.
  always_ff @(posedge clk) begin
    if (cmd.start_iv) begin
      wa         <= src_beat.iv_first_word;
      wb         <= src_beat.iv_second_word;
      sum        <= '0;
      use_iv_key <= 1'b1;
    end else if (cmd.start_data_in) begin
      {wa, wb}   <= src_beat.mode ? src_blk : (src_blk ^ chain);
      sum        <= src_beat.mode ? xcbc_pkg::SUM_DEC : '0;
      use_iv_key <= 1'b0;
    end else if (cmd.start_data_iv) begin
      // The enciphered IV becomes the chain in this same cycle.
      {wa, wb}   <= decrypt ? blk : (blk ^ round_out);
      sum        <= decrypt ? xcbc_pkg::SUM_DEC : '0;
      use_iv_key <= 1'b0;
    end else if (cmd.step) begin
      {wa, wb}   <= round_out;
      sum        <= enc_dir ? e_s : d_s;
    end
  end

  // The chain value is seeded by the enciphered IV and updated after each block.
  always_ff @(posedge clk) begin
    if (rst) begin
      chain <= '0;
    end else if (cmd.start_data_iv) begin
      chain <= round_out;
    end else if (cmd.finish) begin
      chain <= decrypt ? blk : round_out;
    end
  end

  // This is the output register.
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      dst_beat <= decrypt ? (round_out ^ chain) : round_out;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dst_valid <= 1'b0;
    end else if (cmd.finish) begin
      dst_valid <= 1'b1;
    end else if (dst_ready) begin
      dst_valid <= 1'b0;
    end
  end

  // A result is written only into a free output register.
  a_finish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> (!dst_valid || dst_ready))
    else $error("result written over a pending beat");

  // The result beat is presented right after the write.
  a_finish_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> dst_valid)
    else $error("result beat not presented");

endmodule

FILE: design/xcbc_top.sv
// Top level of the XTEA CBC block with encrypted IV. It joins the sequencer and the datapath.
// It depends on xcbc_pkg, xcbc_ctrl and xcbc_dp.
// A plain beat runs the data pass only; a start beat first enciphers its IV in the same round
// unit, one round per cycle, and then runs the data pass. The next beat is taken only in idle,
// so a beat is not accepted before the previous result is written. A stalled output holds the
// last round and adds its wait.
// Reset (synchronous, rst high) clears the keys and the chain to zero and empties the output.
module xtea_cbc_encrypted_iv_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            src_valid,
  output logic                            src_ready,
  input  xcbc_pkg::src_beat_t             src_beat,
  output logic                            dst_valid,
  input  logic                            dst_ready,
  output xcbc_pkg::dst_beat_t             dst_beat,
  input  logic                            cfg_we,
  input  logic [xcbc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                     cfg_data
);

  xcbc_pkg::ctrl_cmd_t cmd;
  xcbc_pkg::ctrl_sts_t sts;

  // This is the sequencer.
  xcbc_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .src_valid     (src_valid),
    .src_ready     (src_ready),
    .start_message (src_beat.start_message),
    .cmd           (cmd),
    .sts           (sts)
  );

  // This is the datapath.
  xcbc_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .src_beat  (src_beat),
    .dst_beat  (dst_beat),
    .dst_valid (dst_valid),
    .dst_ready (dst_ready),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

FILE: dv/xtea_cbc_checker.sv
`timescale 1ns / 100ps
// Checker for the XTEA CBC block with encrypted IV: it predicts each result and compares it.
// It depends on xcbc_pkg for the beat types, register indexes and cipher constants.
module xtea_cbc_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           src_valid,
  input  logic                           src_ready,
  input  xcbc_pkg::src_beat_t            src_beat,
  input  logic                           dst_valid,
  input  logic                           dst_ready,
  input  xcbc_pkg::dst_beat_t            dst_beat,
  input  logic                           cfg_we,
  input  logic [xcbc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data,
  output int unsigned                    fail_count,
  output int unsigned                    pending
);

  typedef logic [3:0][31:0] key_t;

  key_t                data_key;
  key_t                iv_key;
  logic [63:0]         chain;
  xcbc_pkg::dst_beat_t expected_blocks[$];
  xcbc_pkg::dst_beat_t want;

  // Full XTEA encipher of one 64-bit block, first word in the high half.
  function automatic logic [63:0] encipher(input logic [63:0] v, input key_t k);
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] s;
    a = v[63:32];
    b = v[31:0];
    s = '0;
    for (int r = 0; r < xcbc_pkg::ROUNDS; r++) begin
      a += (((b << 4) ^ (b >> 5)) + b) ^ (s + k[s[1:0]]);
      s += xcbc_pkg::DELTA;
      b += (((a << 4) ^ (a >> 5)) + a) ^ (s + k[s[12:11]]);
    end
    return {a, b};
  endfunction

  // Full XTEA decipher: the same rounds run backwards from the final sum.
  function automatic logic [63:0] decipher(input logic [63:0] v, input key_t k);
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] s;
    a = v[63:32];
    b = v[31:0];
    s = xcbc_pkg::SUM_DEC;
    for (int r = 0; r < xcbc_pkg::ROUNDS; r++) begin
      b -= (((a << 4) ^ (a >> 5)) + a) ^ (s + k[s[12:11]]);
      s -= xcbc_pkg::DELTA;
      a -= (((b << 4) ^ (b >> 5)) + b) ^ (s + k[s[1:0]]);
    end
    return {a, b};
  endfunction

  // One CBC step: optionally reseed the chain from the enciphered IV, then process the block.
  function automatic xcbc_pkg::dst_beat_t cbc_step(input xcbc_pkg::src_beat_t b);
    logic [63:0]         blk;
    logic [63:0]         res;
    xcbc_pkg::dst_beat_t r;
    blk = {b.block_first_word, b.block_second_word};
    if (b.start_message)
      chain = encipher({b.iv_first_word, b.iv_second_word}, iv_key);
    if (b.mode == xcbc_pkg::MODE_DECRYPT) begin
      res   = decipher(blk, data_key) ^ chain;
      chain = blk;
    end else begin
      res   = encipher(blk ^ chain, data_key);
      chain = res;
    end
    r.result_first_word  = res[63:32];
    r.result_second_word = res[31:0];
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("checker: %s at %0t", msg, $time);
    fail_count++;
  endtask

  // Track register writes, retire result beats and queue predictions for input beats.
  always @(posedge clk) begin
    if (rst) begin
      data_key = '0;
      iv_key   = '0;
      chain    = '0;
      expected_blocks.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index < xcbc_pkg::REG_IV_KEY0)
          data_key[cfg_index[1:0]] = cfg_data;
        else
          iv_key[cfg_index[1:0]] = cfg_data;
      end
      if (dst_valid && dst_ready) begin
        if (expected_blocks.size() == 0) begin
          report_mismatch($sformatf("unexpected result %08h %08h",
                                    dst_beat.result_first_word, dst_beat.result_second_word));
        end else begin
          want = expected_blocks.pop_front();
          if (dst_beat.result_first_word !== want.result_first_word)
            report_mismatch($sformatf("result_first_word expected %08h got %08h",
                                      want.result_first_word, dst_beat.result_first_word));
          if (dst_beat.result_second_word !== want.result_second_word)
            report_mismatch($sformatf("result_second_word expected %08h got %08h",
                                      want.result_second_word, dst_beat.result_second_word));
        end
      end
      if (src_valid && src_ready)
        expected_blocks.push_back(cbc_step(src_beat));
    end
    pending = expected_blocks.size();
  end

endmodule

FILE: dv/xtea_cbc_encrypted_iv_top_tb.sv
`timescale 1ns / 100ps
// Testbench top for the XTEA CBC block with encrypted IV: stimulus, key setup and verdict.
// It depends on xcbc_pkg, xtea_cbc_encrypted_iv_top and xtea_cbc_checker.
module xtea_cbc_encrypted_iv_top_tb;

  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned SETTLE_CYCLES  = 80;
  localparam int unsigned PHASE_BEATS    = 240;
  localparam int unsigned PHASES         = 6;

  typedef logic [3:0][31:0] key_t;

  logic                           clk;
  logic                           rst;
  logic                           src_valid;
  logic                           src_ready;
  xcbc_pkg::src_beat_t            src_beat;
  logic                           dst_valid;
  logic                           dst_ready;
  xcbc_pkg::dst_beat_t            dst_beat;
  logic                           cfg_we;
  logic [xcbc_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [31:0]                    cfg_data;
  int unsigned                    fail_count;
  int unsigned                    pending;
  int unsigned                    stall_count;
  bit                             tx_gaps;
  bit                             rx_gaps;
  bit                             hold_request;

  xtea_cbc_encrypted_iv_top dut (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_ready (src_ready),
    .src_beat  (src_beat),
    .dst_valid (dst_valid),
    .dst_ready (dst_ready),
    .dst_beat  (dst_beat),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  xtea_cbc_checker block_checker (
    .clk        (clk),
    .rst        (rst),
    .src_valid  (src_valid),
    .src_ready  (src_ready),
    .src_beat   (src_beat),
    .dst_valid  (dst_valid),
    .dst_ready  (dst_ready),
    .dst_beat   (dst_beat),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // A 12 ns clock.
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Most gaps are short, a few are long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80)
      return $urandom_range(1, 3);
    else if (r < 95)
      return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  function automatic key_t rand_key();
    key_t k;
    for (int i = 0; i < 4; i++)
      k[i] = $urandom;
    return k;
  endfunction

  function automatic xcbc_pkg::src_beat_t make_beat(input logic mode, input logic start,
                                          input logic [31:0] iv0, input logic [31:0] iv1,
                                          input logic [31:0] b0, input logic [31:0] b1);
    xcbc_pkg::src_beat_t b;
    b.mode              = mode;
    b.start_message     = start;
    b.iv_first_word     = iv0;
    b.iv_second_word    = iv1;
    b.block_first_word  = b0;
    b.block_second_word = b1;
    return b;
  endfunction

  function automatic xcbc_pkg::src_beat_t random_beat();
    return make_beat(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     $urandom, $urandom, $urandom, $urandom);
  endfunction

  // Offer one beat after an optional gap and hold it until the block takes it.
  task automatic push_block(input xcbc_pkg::src_beat_t b);
    if (tx_gaps && $urandom_range(0, 99) < 35) begin
      src_valid <= 1'b0;
      repeat (pick_gap()) @(negedge clk);
    end
    src_valid <= 1'b1;
    src_beat  <= b;
    do @(posedge clk); while (!src_ready);
    @(negedge clk);
  endtask

  // Stop offering and wait until every predicted result has come back.
  task automatic drain();
    src_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Write all eight key registers, one per cycle.
  task automatic write_keys(input key_t dk, input key_t ik);
    xcbc_pkg::cfg_reg_t r;
    r = xcbc_pkg::REG_DATA_KEY0;
    cfg_we <= 1'b1;
    for (int i = 0; i < r.num(); i++) begin
      cfg_index <= r;
      cfg_data  <= (r < xcbc_pkg::REG_IV_KEY0) ? dk[r[1:0]] : ik[r[1:0]];
      r = r.next();
      @(negedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // Mostly whole messages (start beat, then chained beats) with random content, some noise.
  task automatic run_messages(input int unsigned count, input bit with_hold);
    int unsigned         sent;
    int unsigned         len;
    logic                m;
    xcbc_pkg::src_beat_t b;
    bit                  held;
    sent = 0;
    held = 1'b0;
    while (sent < count) begin
      if ($urandom_range(0, 9) == 0) tx_gaps = !tx_gaps;
      if ($urandom_range(0, 9) == 0) rx_gaps = !rx_gaps;
      if (with_hold && !held && sent >= count / 2) begin
        hold_request = 1'b1;
        held = 1'b1;
      end
      if ($urandom_range(0, 99) < 85) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
        m = 1'($urandom_range(0, 1));
        for (int i = 0; i < len; i++) begin
          b = random_beat();
          b.mode = ($urandom_range(0, 19) == 0) ? !m : m;
          b.start_message = (i == 0);
          push_block(b);
          sent++;
        end
      end else begin
        push_block(random_beat());
        sent++;
      end
    end
  endtask

  // Watchdog: too long without any beat on either channel ends the run.
  always @(posedge clk) begin
    if (rst || (src_valid && src_ready) || (dst_valid && dst_ready)) begin
      stall_count <= 0;
    end else if (stall_count + 1 >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      stall_count <= stall_count + 1;
    end
  end

  // Result side: random back-pressure, plus one long hold-off when asked.
  initial begin
    dst_ready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        dst_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (rx_gaps && $urandom_range(0, 99) < 30) begin
        dst_ready <= 1'b0;
        repeat (pick_gap()) @(negedge clk);
      end else begin
        dst_ready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  // Main sequence: reset, directed beats, then random messages under several key settings.
  initial begin
    rst          = 1'b1;
    src_valid    = 1'b0;
    src_beat     = '0;
    cfg_we       = 1'b0;
    cfg_index    = xcbc_pkg::REG_DATA_KEY0;
    cfg_data     = '0;
    tx_gaps      = 1'b0;
    rx_gaps      = 1'b0;
    hold_request = 1'b0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // Keys and chain still at reset: no start yet, IV words must be ignored.
    push_block(make_beat(xcbc_pkg::MODE_ENCRYPT, 1'b0, $urandom, $urandom, '0, '0));
    push_block(make_beat(xcbc_pkg::MODE_DECRYPT, 1'b0, '1, '1, '1, '1));
    push_block(make_beat(xcbc_pkg::MODE_ENCRYPT, 1'b0, $urandom, $urandom, $urandom, $urandom));
    drain();

    // Random keys: word extremes, mode changes inside a message, back-to-back starts.
    write_keys(rand_key(), rand_key());
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
    push_block(make_beat(xcbc_pkg::MODE_ENCRYPT, 1'b1, '0, '0, '0, '0));
    push_block(make_beat(xcbc_pkg::MODE_ENCRYPT, 1'b0, $urandom, $urandom, '1, '1));
    push_block(make_beat(xcbc_pkg::MODE_DECRYPT, 1'b0, $urandom, $urandom, $urandom, $urandom));
    push_block(make_beat(xcbc_pkg::MODE_ENCRYPT, 1'b0, $urandom, $urandom, $urandom, $urandom));
    push_block(make_beat(xcbc_pkg::MODE_DECRYPT, 1'b1, '1, '1, '1, '1));
    push_block(make_beat(xcbc_pkg::MODE_DECRYPT, 1'b0, '1, '1, '0, '0));
    push_block(make_beat(xcbc_pkg::MODE_DECRYPT, 1'b0, $urandom, $urandom, $urandom, $urandom));
    push_block(make_beat(xcbc_pkg::MODE_ENCRYPT, 1'b1, '1, '0, '0, '1));
    push_block(make_beat(xcbc_pkg::MODE_DECRYPT, 1'b1, '0, '1, '1, '0));
    push_block(make_beat(xcbc_pkg::MODE_ENCRYPT, 1'b1, $urandom, $urandom, $urandom, $urandom));
    drain();

    // All-ones keys.
    write_keys('1, '1);
    push_block(make_beat(xcbc_pkg::MODE_ENCRYPT, 1'b1, '1, '1, '0, '0));
    push_block(make_beat(xcbc_pkg::MODE_DECRYPT, 1'b0, $urandom, $urandom, $urandom, $urandom));
    push_block(make_beat(xcbc_pkg::MODE_ENCRYPT, 1'b0, $urandom, $urandom, $urandom, $urandom));
    drain();

    // Random messages, one key setting per phase; one phase includes the long hold-off.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: write_keys('0, '1);
        1: write_keys('1, '0);
        2: write_keys(rand_key(), rand_key());
        3: write_keys('1, '1);
        4: write_keys(rand_key(), '0);
        default: write_keys(rand_key(), rand_key());
      endcase
      run_messages(PHASE_BEATS, p == 2);
      drain();
    end

    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
